>>> sv/pdc_pkg.sv
// Shared types, letter codes and square geometry helpers for the Playfair cipher block.
`default_nettype none

package pdc_pkg;

    localparam int SQ_SIDE  = 5;
    localparam int SQ_CELLS = 25;
    localparam int LETTERS  = 26;

    localparam logic [4:0] LTR_I = 5'd8;
    localparam logic [4:0] LTR_J = 5'd9;
    localparam logic [4:0] LTR_X = 5'd23;
    localparam logic [4:0] LTR_Z = 5'd25;

    localparam logic [1:0] ACT_KEY  = 2'd0;
    localparam logic [1:0] ACT_TEXT = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
    } t_pos_pair;

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        cell_addr = {row, 2'b00} + 5'(row) + 5'(col);
    endfunction

    function automatic logic [2:0] pos_row(input logic [4:0] pos);
        if (pos >= 5'd20) begin
            pos_row = 3'd4;
        end else if (pos >= 5'd15) begin
            pos_row = 3'd3;
        end else if (pos >= 5'd10) begin
            pos_row = 3'd2;
        end else if (pos >= 5'd5) begin
            pos_row = 3'd1;
        end else begin
            pos_row = 3'd0;
        end
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] pos);
        pos_col = 3'(pos - cell_addr(pos_row(pos), 3'd0));
    endfunction

    function automatic logic [2:0] inc5(input logic [2:0] v);
        inc5 = (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/pdc_cell_calc.sv
// Digram rule: maps the square positions of a letter pair to the cells of the cipher pair.
`default_nettype none

module pdc_cell_calc
    import pdc_pkg::*;
(
    input  wire t_pos_pair i_pos,
    output t_pos_pair      o_cell
);

    logic [2:0] ra, ca, rb, cb;

    always_comb begin
        ra = pos_row(i_pos.a);
        ca = pos_col(i_pos.a);
        rb = pos_row(i_pos.b);
        cb = pos_col(i_pos.b);
        if (ra == rb) begin
            o_cell.a = cell_addr(ra, inc5(ca));
            o_cell.b = cell_addr(rb, inc5(cb));
        end else if (ca == cb) begin
            o_cell.a = cell_addr(inc5(ra), ca);
            o_cell.b = cell_addr(inc5(rb), cb);
        end else begin
            o_cell.a = cell_addr(ra, cb);
            o_cell.b = cell_addr(rb, ca);
        end
    end

endmodule

`default_nettype wire

>>> sv/playfair_digram_cipher.sv
// Playfair digram encryptor: key square memories, pairing control and output stream.
//
// Input stream: tuser carries the action (key letter, plaintext letter, end of
// message), tdata[4:0] the letter code. Output stream: tdata[4:0] the cipher
// letter, tlast set on the second letter of each pair.
// One transaction is in work at a time; tready is low while it is processed.
// Key letters are written straight into the square.
// The first plaintext letter of a message starts a sweep over a..z that
// completes the square. A letter that only opens a pair is held.
// A letter that closes a pair, or an end of message with a pair open, reads
// the letter positions on acceptance, then the two square cells in S_RDP;
// the first cipher letter is offered in S_OUT0 and the second in S_OUT1
// once the first is taken. A stalled receiver holds the offered letter and
// blocks further input. Reset clears the used-letter set, fill count and
// pairing state; the square memories are not cleared, every entry is written
// before it is read.
`default_nettype none

module playfair_digram_cipher
    import pdc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [4:0] letter
    input  wire  [1:0] i_s_axis_tuser,   // [1:0] action
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [4:0] cipher_letter
    output logic       o_m_axis_tlast    // last_of_run
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_RDP  = 3'd2;
    localparam logic [2:0] S_OUT0 = 3'd3;
    localparam logic [2:0] S_OUT1 = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [25:0] r_used, n_used;
    logic [4:0]  r_fill, n_fill;
    logic        r_text, n_text;
    logic [4:0]  r_held, n_held;
    logic        r_pair, n_pair;
    logic [4:0]  r_scan, n_scan;
    logic [4:0]  r_cur, n_cur;

    logic [4:0]  r_key_sq [SQ_CELLS];
    logic [4:0]  r_place  [LETTERS];
    t_pos_pair   r_pos;
    logic [4:0]  r_ka, r_kb;

    logic        in_acc;
    logic [4:0]  ltr;
    logic        wr_en;
    logic [4:0]  wr_ltr;
    logic        rd_en;
    t_pos_pair   rd_ltr;
    logic        key_rd;
    t_pos_pair   sq_cell;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign ltr    = (i_s_axis_tdata[4:0] == LTR_J) ? LTR_I : i_s_axis_tdata[4:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign o_m_axis_tdata  = {3'b000, (r_state == S_OUT1) ? r_kb : r_ka};
    assign o_m_axis_tlast  = (r_state == S_OUT1);

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_fill   = r_fill;
        n_text   = r_text;
        n_held   = r_held;
        n_pair   = r_pair;
        n_scan   = r_scan;
        n_cur    = r_cur;
        wr_en    = 1'b0;
        wr_ltr   = ltr;
        rd_en    = 1'b0;
        rd_ltr.a = r_held;
        rd_ltr.b = LTR_X;
        key_rd   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_s_axis_tuser)
                        ACT_KEY: begin
                            if (ltr <= LTR_Z && !r_text && !r_used[ltr]
                                && r_fill < 5'(SQ_CELLS)) begin
                                wr_en = 1'b1;
                            end
                        end
                        ACT_TEXT: begin
                            if (ltr <= LTR_Z) begin
                                if (!r_text) begin
                                    n_cur   = ltr;
                                    n_scan  = 5'd0;
                                    n_state = S_FILL;
                                end else if (!r_pair) begin
                                    n_held = ltr;
                                    n_pair = 1'b1;
                                end else begin
                                    rd_en   = 1'b1;
                                    n_state = S_RDP;
                                    if (ltr != r_held) begin
                                        rd_ltr.b = ltr;
                                        n_pair   = 1'b0;
                                    end
                                end
                            end
                        end
                        ACT_END: begin
                            if (r_pair && r_text) begin
                                rd_en   = 1'b1;
                                n_state = S_RDP;
                            end
                            n_used = '0;
                            n_fill = '0;
                            n_text = 1'b0;
                            n_held = '0;
                            n_pair = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                wr_ltr = r_scan;
                if (r_scan != LTR_J && !r_used[r_scan] && r_fill < 5'(SQ_CELLS)) begin
                    wr_en = 1'b1;
                end
                n_scan = r_scan + 5'd1;
                if (r_scan == LTR_Z) begin
                    n_text  = 1'b1;
                    n_held  = r_cur;
                    n_pair  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RDP: begin
                key_rd  = 1'b1;
                n_state = S_OUT0;
            end
            S_OUT0: begin
                if (i_m_axis_tready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (wr_en) begin
            n_used[wr_ltr] = 1'b1;
            n_fill         = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_fill  <= '0;
            r_text  <= 1'b0;
            r_held  <= '0;
            r_pair  <= 1'b0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_fill  <= n_fill;
            r_text  <= n_text;
            r_held  <= n_held;
            r_pair  <= n_pair;
            r_scan  <= n_scan;
        end
        r_cur <= n_cur;
    end

    // writes and reads never fall in the same cycle, so no forwarding
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_sq[r_fill] <= wr_ltr;
            r_place[wr_ltr]  <= r_fill;
        end
        if (rd_en) begin
            r_pos.a <= r_place[rd_ltr.a];
            r_pos.b <= r_place[rd_ltr.b];
        end
        if (key_rd) begin
            r_ka <= r_key_sq[sq_cell.a];
            r_kb <= r_key_sq[sq_cell.b];
        end
    end

    pdc_cell_calc u_cell_calc (
        .i_pos  (r_pos),
        .o_cell (sq_cell)
    );

endmodule

`default_nettype wire
